FILE: design/label_boundary_extract_3x3_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the label boundary extractor
// Concurrent checks that vanish when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef LABEL_BOUNDARY_EXTRACT_3X3_MACROS_SVH
`define LABEL_BOUNDARY_EXTRACT_3X3_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LBE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbe assertion failed");

// next-cycle implication
`define LBE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbe assertion failed");

`else

`define LBE_ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`define LBE_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/lbe_pkg.sv
// ----------------------------------------------------------------------------
// lbe_pkg
// Shared widths, register indexes and types of the label boundary extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package lbe_pkg;

	localparam int LABEL_W      = 24;   // label and color width
	localparam int CFG_W        = 24;   // widest register
	localparam int CFG_IDX_W    = 2;
	localparam int WIDTH_REG_W  = 14;
	localparam int HEIGHT_REG_W = 13;
	localparam int IN_ROW_W     = 14;   // input row runs one row past the frame
	localparam int CMP_W        = 17;   // holds MAX_WIDTH up to 65536
	localparam int FIFO_DEPTH   = 3;
	localparam int FIFO_PTR_W   = 2;

	localparam int DEF_MAX_WIDTH = 8192;
	localparam int DEF_WIDTH     = 8192;
	localparam int DEF_HEIGHT    = 4096;
	localparam logic [LABEL_W-1:0] DEF_BORDER = 24'hFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_BORDER = 2'd2
	} cfg_reg_t;

	// position flags of a result, worked out at accept time
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
		logic last;
	} pos_flags_t;

endpackage

`default_nettype wire

FILE: design/lbe_ram.sv
// ----------------------------------------------------------------------------
// lbe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lbe_ram #(
	parameter int DATA_W = 24,
	parameter int DEPTH  = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: design/label_boundary_extract_3x3.sv
// Path: the word that completes a pixel's neighborhood, image_width + 1 words after the
//   pixel itself, is registered in stage 1, and the result then waits in the output queue.
// Throughput: one word per cycle while the output queue has room; each line RAM: one read, one write per cycle.
// Reset: counters, window control and output queue clear at once; the line RAMs are
//   not cleared and need no clearing pass (unwritten entries only feed edge neighbors).
// ----------------------------------------------------------------------------
// label_boundary_extract_3x3
// Boundary map of a raster label image over a 3x3 window kept in two line RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "label_boundary_extract_3x3_macros.svh"

module label_boundary_extract_3x3
	import lbe_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write port
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	// input stream
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [LABEL_W-1:0]   s_tdata,   // [23:0] pixel_label
	input  wire logic                 s_tuser,   // [0] drain
	// result stream
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [LABEL_W-1:0]   m_tdata,   // [23:0] out_pixel
	output logic                      m_tuser,   // [0] is_border
	output logic                      m_tlast    // last_of_frame
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int XW  = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;
	localparam int WCAP = (MAX_WIDTH > 16384) ? 16384 : MAX_WIDTH;
	localparam int WRST = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
	localparam logic [WIDTH_REG_W-1:0]  WLAST_MAX = WIDTH_REG_W'(WCAP - 1);
	localparam logic [WIDTH_REG_W-1:0]  WLAST_RST = WIDTH_REG_W'(WRST - 1);
	localparam logic [HEIGHT_REG_W-1:0] HLAST_RST = HEIGHT_REG_W'(DEF_HEIGHT - 1);

	typedef struct packed {
		logic               last;
		logic               border;
		logic [LABEL_W-1:0] pixel;
	} result_t;

	// configuration, kept as last column / last row
	logic [WIDTH_REG_W-1:0]  wlast_q;
	logic [HEIGHT_REG_W-1:0] hlast_q;
	logic [LABEL_W-1:0]      border_q;

	// position counters
	logic [CW-1:0]           in_col_q;
	logic [IN_ROW_W-1:0]     in_row_q;
	logic [CW-1:0]           out_col_q;
	logic [HEIGHT_REG_W-1:0] out_row_q;

	// stage 1
	logic                    valid_s1;
	logic                    res_s1;
	logic [LABEL_W-1:0]      label_s1;
	logic [CW-1:0]           col_s1;
	pos_flags_t              flags_s1;
	logic                    fwd_s1;
	logic [LABEL_W-1:0]      fwd_up_s1;
	logic [LABEL_W-1:0]      fwd_mid_s1;

	logic [LABEL_W-1:0]      win_q [3][3];

	// output queue
	result_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_PTR_W-1:0]   cnt_q;

	logic                    accept;
	logic                    past_frame;
	logic                    active;
	logic                    ready_now;
	logic                    col_end;
	logic [LABEL_W-1:0]      label_in;
	pos_flags_t              flags_now;
	logic [WIDTH_REG_W-1:0]  wlast_new;
	logic [LABEL_W-1:0]      up_rd;
	logic [LABEL_W-1:0]      mid_rd;
	logic [LABEL_W-1:0]      up_eff;
	logic [LABEL_W-1:0]      mid_eff;
	logic                    push;
	logic                    pop;
	logic                    is_border;
	result_t                 res_new;

	// ---------------------------------------------------------------- accept
	assign push       = valid_s1 && res_s1;
	assign pop        = m_tvalid && m_tready;
	assign s_tready   = (3'(cnt_q) + 3'(push)) < 3'(FIFO_DEPTH);
	assign accept     = s_tvalid && s_tready;
	assign past_frame = in_row_q > {1'b0, hlast_q};
	assign active     = accept && (past_frame || !s_tuser);
	assign label_in   = past_frame ? '0 : s_tdata;
	assign ready_now  = (in_row_q != '0) &&
		!((in_row_q == IN_ROW_W'(1)) && (in_col_q == '0));
	assign col_end    = XW'(in_col_q) == XW'(wlast_q);

	assign flags_now.top    = out_row_q == '0;
	assign flags_now.bottom = out_row_q == hlast_q;
	assign flags_now.left   = out_col_q == '0;
	assign flags_now.right  = XW'(out_col_q) == XW'(wlast_q);
	assign flags_now.last   = flags_now.bottom && flags_now.right;

	// width write: zero means one, saturate at MAX_WIDTH
	always_comb begin
		if (cfg_data[WIDTH_REG_W-1:0] == '0) begin
			wlast_new = '0;
		end else if (CMP_W'(cfg_data[WIDTH_REG_W-1:0]) > CMP_W'(MAX_WIDTH)) begin
			wlast_new = WLAST_MAX;
		end else begin
			wlast_new = cfg_data[WIDTH_REG_W-1:0] - WIDTH_REG_W'(1);
		end
	end

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlast_q   <= WLAST_RST;
			hlast_q   <= HLAST_RST;
			border_q  <= DEF_BORDER;
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_WIDTH: begin
					wlast_q   <= wlast_new;
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_HEIGHT: begin
					hlast_q   <= (cfg_data[HEIGHT_REG_W-1:0] == '0) ? '0 :
						cfg_data[HEIGHT_REG_W-1:0] - HEIGHT_REG_W'(1);
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
				end
				REG_BORDER: begin
					border_q <= cfg_data[LABEL_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (active) begin
			if (ready_now && flags_now.last) begin
				// final result of the frame: start over
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (col_end) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + IN_ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (ready_now) begin
					if (flags_now.right) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HEIGHT_REG_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- line RAMs
	lbe_ram #(
		.DATA_W (LABEL_W),
		.DEPTH  (MAX_WIDTH)
	) u_upper_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (mid_eff),
		.re    (active),
		.raddr (in_col_q),
		.rdata (up_rd)
	);

	lbe_ram #(
		.DATA_W (LABEL_W),
		.DEPTH  (MAX_WIDTH)
	) u_middle_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (label_s1),
		.re    (active),
		.raddr (in_col_q),
		.rdata (mid_rd)
	);

	// forward the write of the word ahead when it hits the same column
	assign up_eff  = fwd_s1 ? fwd_up_s1  : up_rd;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : mid_rd;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			res_s1   <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			valid_s1 <= active;
			res_s1   <= active && ready_now;
			fwd_s1   <= active && valid_s1 && (col_s1 == in_col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			label_s1   <= label_in;
			col_s1     <= in_col_q;
			flags_s1   <= flags_now;
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= label_s1;
		end
	end

	// window shift: new right column from the RAMs and the incoming label
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			for (int y = 0; y < 3; y++) begin
				win_q[y][0] <= win_q[y][1];
				win_q[y][1] <= win_q[y][2];
			end
			win_q[0][2] <= up_eff;
			win_q[1][2] <= mid_eff;
			win_q[2][2] <= label_s1;
		end
	end

	// classify the center of the shifted window
	always_comb begin
		logic [LABEL_W-1:0] center;
		logic               differs;
		center  = win_q[1][2];
		differs = (win_q[0][1] != center) || (win_q[0][2] != center) ||
			(up_eff != center) || (win_q[1][1] != center) ||
			(mid_eff != center) || (win_q[2][1] != center) ||
			(win_q[2][2] != center) || (label_s1 != center);
		is_border = (center != '0) && (differs || flags_s1.top || flags_s1.bottom ||
			flags_s1.left || flags_s1.right);
		res_new.last   = flags_s1.last;
		res_new.border = is_border;
		res_new.pixel  = is_border ? border_q : '0;
	end

	// ---------------------------------------------------------------- output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
					wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 :
					rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_PTR_W'(push) - FIFO_PTR_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_new;
		end
	end

	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = fifo_q[rd_ptr_q].pixel;
	assign m_tuser  = fifo_q[rd_ptr_q].border;
	assign m_tlast  = fifo_q[rd_ptr_q].last;

	// ---------------------------------------------------------------- checks
	`LBE_ASSERT_IMPLY(a_queue_room, clk, arst_n, push, (cnt_q < FIFO_PTR_W'(FIFO_DEPTH)) || pop)
	`LBE_ASSERT_NEXT(a_drain_dropped, clk, arst_n, accept && s_tuser && !past_frame && !cfg_we, !valid_s1)
	`LBE_ASSERT_NEXT(a_frame_restart, clk, arst_n, active && ready_now && flags_now.last && !cfg_we, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0))
	`LBE_ASSERT_IMPLY(a_fwd_same_col, clk, arst_n, fwd_s1, valid_s1)

endmodule

`default_nettype wire

FILE: bench/lbe_boundary_checker.sv
// ----------------------------------------------------------------------------
// lbe_boundary_checker
// Passive checker of the label boundary extractor. It snoops the register
// port and both streams, keeps its own line stores, window and frame counters,
// predicts one boundary word per undropped input word once a row-plus-one-word lag has
// filled, and compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module lbe_boundary_checker
	import lbe_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [LABEL_W-1:0]   s_tdata,   // [23:0] pixel_label
	input  wire logic                 s_tuser,   // [0] drain
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	input  wire logic [LABEL_W-1:0]   m_tdata,   // [23:0] out_pixel
	input  wire logic                 m_tuser,   // [0] is_border
	input  wire logic                 m_tlast,   // last_of_frame
	output int                        fail_count,
	output int                        expected_left,
	output int                        results_seen,
	output int                        border_seen,
	output int                        frames_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LINE_DEPTH = DEF_MAX_WIDTH;

	typedef struct packed {
		logic [LABEL_W-1:0] pixel;
		logic               border;
		logic               last;
	} boundary_word_t;

	// register copies
	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [LABEL_W-1:0]      border_reg;

	// neighborhood state
	logic [LABEL_W-1:0] upper_line  [LINE_DEPTH];
	logic [LABEL_W-1:0] middle_line [LINE_DEPTH];
	logic [LABEL_W-1:0] win [3][3];
	int unsigned        in_col, in_row;
	int unsigned        out_idx, out_col, out_row;

	boundary_word_t expected_boundary [$];

	function automatic int unsigned frame_width();
		if (width_reg == '0)
			return 1;
		if (width_reg > LINE_DEPTH)
			return LINE_DEPTH;
		return width_reg;
	endfunction

	function automatic int unsigned frame_height();
		return (height_reg == '0) ? 1 : height_reg;
	endfunction

	task automatic restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_idx = 0;
		out_col = 0;
		out_row = 0;
	endtask

	// one accepted input word: shift the window, maybe emit a boundary word
	task automatic predict_boundary(input logic [LABEL_W-1:0] label_in, input logic drain_in);
		int unsigned        w, h;
		logic [LABEL_W-1:0] lbl, center;
		bit                 ready, border, last, outside;
		boundary_word_t     bw;
		w = frame_width();
		h = frame_height();
		// a drain while pixels are still due is dropped
		if (!(in_row < h && drain_in)) begin
			// past the last pixel every word flushes, its label unused
			lbl = (in_row < h) ? label_in : '0;
			ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			for (int y = 0; y < 3; y++) begin
				win[y][0] = win[y][1];
				win[y][1] = win[y][2];
			end
			win[0][2] = upper_line[in_col];
			win[1][2] = middle_line[in_col];
			win[2][2] = lbl;
			upper_line[in_col]  = middle_line[in_col];
			middle_line[in_col] = lbl;
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (ready) begin
				center = win[1][1];
				border = 1'b0;
				// background never borders; a label borders on the edge or a change
				if (center != '0) begin
					for (int dy = 0; dy < 3; dy++) begin
						for (int dx = 0; dx < 3; dx++) begin
							outside = (dy == 0 && out_row == 0) ||
								(dy == 2 && out_row + 1 >= h) ||
								(dx == 0 && out_col == 0) ||
								(dx == 2 && out_col + 1 >= w);
							if (outside || win[dy][dx] != center)
								border = 1'b1;
						end
					end
				end
				last = (longint'(out_idx) + 1 == longint'(w) * longint'(h));
				bw.pixel  = border ? border_reg : '0;
				bw.border = border;
				bw.last   = last;
				expected_boundary.push_back(bw);
				if (last) begin
					restart_frame();
				end else begin
					out_idx++;
					out_col++;
					if (out_col >= w) begin
						out_col = 0;
						out_row++;
					end
				end
			end
		end
	endtask

	// snoop, predict and compare
	always @(posedge clk or negedge arst_n) begin
		int             errs, n_res, n_brd, n_frm;
		boundary_word_t got, want;
		if (!arst_n) begin
			width_reg  = DEF_WIDTH;
			height_reg = DEF_HEIGHT;
			border_reg = DEF_BORDER;
			for (int i = 0; i < LINE_DEPTH; i++) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			for (int y = 0; y < 3; y++)
				for (int x = 0; x < 3; x++)
					win[y][x] = '0;
			restart_frame();
			expected_boundary.delete();
			fail_count    <= 0;
			expected_left <= 0;
			results_seen  <= 0;
			border_seen   <= 0;
			frames_seen   <= 0;
		end else begin
			errs  = 0;
			n_res = 0;
			n_brd = 0;
			n_frm = 0;
			// register writes; a size write restarts the frame
			if (cfg_we) begin
				case (cfg_idx)
					REG_WIDTH: begin
						width_reg = cfg_data[WIDTH_REG_W-1:0];
						restart_frame();
					end
					REG_HEIGHT: begin
						height_reg = cfg_data[HEIGHT_REG_W-1:0];
						restart_frame();
					end
					REG_BORDER: border_reg = cfg_data[LABEL_W-1:0];
					default: ;
				endcase
			end
			// result word against the oldest prediction
			if (m_tvalid && m_tready) begin
				got = '{m_tdata, m_tuser, m_tlast};
				n_res = 1;
				n_brd = m_tuser ? 1 : 0;
				n_frm = m_tlast ? 1 : 0;
				if (expected_boundary.size() == 0) begin
					$display("%0t: result word with none expected: pixel=%06h border=%b last=%b",
						$time, got.pixel, got.border, got.last);
					errs++;
				end else begin
					want = expected_boundary.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch: expected pixel=%06h border=%b last=%b, got pixel=%06h border=%b last=%b",
							$time, want.pixel, want.border, want.last,
							got.pixel, got.border, got.last);
						errs++;
					end
				end
			end
			if (s_tvalid && s_tready)
				predict_boundary(s_tdata, s_tuser);
			fail_count    <= fail_count + errs;
			results_seen  <= results_seen + n_res;
			border_seen   <= border_seen + n_brd;
			frames_seen   <= frames_seen + n_frm;
			expected_left <= expected_boundary.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the label boundary extractor bench. Drives label frames in raster
// order with drain words, rewrites the frame size and border color between
// frames (zero and saturated sizes included), abandons and pauses frames,
// and runs under four idling modes on both streams. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lbe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;   // unmapped, must be ignored
	localparam int RANDOM_WORDS  = 950;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 100000;

	typedef enum {PAT_UNIFORM, PAT_BLOCKS, PAT_PALETTE, PAT_NOISE} pattern_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 cfg_we   = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx  = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [LABEL_W-1:0]   s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [LABEL_W-1:0]   m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int fail_count, expected_left, results_seen, border_seen, frames_seen;

	// stimulus knobs
	int                 src_idle_pct  = 0;
	int                 snk_stall_pct = 0;
	int                 noise_pct     = 0;
	int                 block_shift   = 0;
	int                 frame_words   = 0;
	pattern_t           pattern       = PAT_UNIFORM;
	logic [LABEL_W-1:0] palette [4];

	label_boundary_extract_3x3 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	lbe_boundary_checker boundary_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.fail_count    (fail_count),
		.expected_left (expected_left),
		.results_seen  (results_seen),
		.border_seen   (border_seen),
		.frames_seen   (frames_seen)
	);

	always #4 clk = ~clk;

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	function automatic logic [LABEL_W-1:0] rand_label();
		rand_label = LABEL_W'($urandom());
	endfunction

	function automatic logic [LABEL_W-1:0] frame_label(input int r, input int c);
		case (pattern)
			PAT_UNIFORM: return palette[1];
			PAT_BLOCKS:  return palette[((r >> block_shift) + (c >> block_shift)) & 3];
			PAT_PALETTE: return palette[$urandom_range(3)];
			default:     return rand_label();
		endcase
	endfunction

	task automatic new_palette();
		palette[0] = ($urandom_range(1) != 0) ? '0 : rand_label();
		palette[1] = ($urandom_range(7) == 0) ? '1 : rand_label();
		palette[2] = rand_label();
		palette[3] = rand_label();
	endtask

	// 0: none, 1: sender idle, 2: receiver stalls, 3: both lightly
	task automatic set_idling(input int mode);
		case (mode)
			1:       begin src_idle_pct = 86; snk_stall_pct = 0;  end
			2:       begin src_idle_pct = 0;  snk_stall_pct = 86; end
			3:       begin src_idle_pct = 23; snk_stall_pct = 23; end
			default: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
		endcase
	endtask

	// one input word; valid stays high into the next word unless a gap falls
	task automatic push_word(input logic [LABEL_W-1:0] label, input logic drain);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= label;
		s_tuser  <= drain;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold off the sender until every predicted word is out, then settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_frame(input int raw_w, input int raw_h);
		wait_idle();
		write_reg(REG_WIDTH, CFG_W'(raw_w));
		write_reg(REG_HEIGHT, CFG_W'(raw_h));
	endtask

	// pixels in raster order, then width + 1 flush words unless abandoned
	task automatic run_frame(input int w, input int h, input int stop_after, input int pause_at);
		for (int n = 0; n < w * h && n != stop_after; n++) begin
			if (n == pause_at)
				wait_idle();
			if ($urandom_range(99) < noise_pct)
				push_word(rand_label(), 1'b1);
			push_word(frame_label(n / w, n % w), 1'b0);
			frame_words++;
		end
		if (stop_after < 0) begin
			// mostly drains, some late pixels that act as drains
			repeat (w + 1) begin
				push_word(rand_label(), $urandom_range(3) != 0);
				frame_words++;
			end
		end
	endtask

	initial begin
		int                 w, h, frame_no, rand_base, stop_at, pause_pos, waited;
		logic [CFG_W-1:0]   cfg_val;
		logic [LABEL_W-1:0] color;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(0);

		// directed: 3x2 with label extremes, an early drain and a late pixel,
		// size data carries junk above the register width
		write_reg(REG_WIDTH, 24'hFFC003);
		write_reg(REG_HEIGHT, 24'hFFE002);
		push_word(24'hFFFFFF, 1'b0);
		push_word(24'h000000, 1'b0);
		push_word(24'h123456, 1'b1);   // ignored: pixels still due
		push_word(24'h000001, 1'b0);
		push_word(24'hFFFFFF, 1'b0);
		push_word(24'hFFFFFF, 1'b0);
		push_word(24'h000000, 1'b0);
		push_word(rand_label(), 1'b1);
		push_word(rand_label(), 1'b1);
		push_word(24'hABCDEF, 1'b0);   // pixel after the frame flushes
		push_word(rand_label(), 1'b1);

		// directed: 3x3 uniform, the center is interior; spare index ignored
		wait_idle();
		write_reg(REG_SPARE, 24'hFFFFFF);
		start_frame(3, 3);
		pattern = PAT_UNIFORM;
		palette[1] = 24'h5A5A5A;
		run_frame(3, 3, -1, -1);

		// size write in the middle of a frame restarts it
		start_frame(4, 3);
		pattern = PAT_PALETTE;
		new_palette();
		run_frame(4, 3, 7, -1);
		start_frame(5, 3);
		write_reg(REG_BORDER, 24'h000000);
		pattern = PAT_BLOCKS;
		block_shift = 1;
		run_frame(5, 3, -1, -1);

		// zero sizes act as one
		start_frame(0, 0);
		write_reg(REG_BORDER, 24'hFFFFFF);
		run_frame(1, 1, -1, -1);

		// random frames across the idling modes
		rand_base = frame_words;
		frame_no  = 0;
		noise_pct = 3;
		while (frame_words - rand_base < RANDOM_WORDS) begin
			set_idling(frame_no % 4);
			w = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10, 1);
			h = ($urandom_range(9) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 1);
			wait_idle();
			cfg_val = ($urandom_range(1) != 0) ? rand_label() : '0;
			cfg_val[WIDTH_REG_W-1:0] = w[WIDTH_REG_W-1:0];
			write_reg(REG_WIDTH, cfg_val);
			cfg_val = ($urandom_range(1) != 0) ? rand_label() : '0;
			cfg_val[HEIGHT_REG_W-1:0] = h[HEIGHT_REG_W-1:0];
			write_reg(REG_HEIGHT, cfg_val);
			if ($urandom_range(1) != 0) begin
				case ($urandom_range(7))
					0:       color = '0;
					1:       color = '1;
					default: color = rand_label();
				endcase
				write_reg(REG_BORDER, color);
			end
			if ($urandom_range(15) == 0)
				write_reg(REG_SPARE, rand_label());
			pattern = pattern_t'($urandom_range(3));
			block_shift = $urandom_range(2);
			new_palette();
			stop_at = -1;
			if (w * h > 1 && (frame_no == 1 || $urandom_range(11) == 0))
				stop_at = $urandom_range(w * h - 1, 1);
			pause_pos = (frame_no == 3 || $urandom_range(15) == 0) ? $urandom_range(w * h - 1) : -1;
			run_frame(w, h, stop_at, pause_pos);
			frame_no++;
		end

		// saturated width: a short first row that is then abandoned
		noise_pct = 0;
		set_idling(0);
		start_frame(24'h3FFF, 2);
		write_reg(REG_BORDER, rand_label());
		pattern = PAT_NOISE;
		run_frame(DEF_MAX_WIDTH, 2, 24, -1);
		// tallest height in one column, top part only
		start_frame(1, 24'h1FFF);
		pattern = PAT_PALETTE;
		new_palette();
		run_frame(1, 8191, 12, -1);
		// a last full frame with both sides idling
		set_idling(3);
		start_frame(3, 6);
		pattern = PAT_BLOCKS;
		block_shift = 1;
		new_palette();
		run_frame(3, 6, -1, -1);

		// drain the tail with a bound, then settle
		s_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (expected_left != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d frames, %0d result words (%0d on a boundary), %0d frame words",
			frames_seen, results_seen, border_seen, frame_words);
		$display("Sizes 1x1 to 40x20 plus saturated ones, %0d left over, %0d mismatches",
			expected_left, fail_count);
		if (fail_count == 0 && expected_left == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// run limit
	initial begin
		#50_000_000;
		$display("Timeout with %0d result words still expected", expected_left);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
